/* sv/esd_pkg.sv */
// ----------------------------------------------------------------------------
// esd_pkg
// shared types and constants for the escape sequence decoder
// ----------------------------------------------------------------------------
package esd_pkg;

    // default depth of the job queue between front and back
    localparam int JOB_DEPTH = 4;

    // one decoded job: up to four number bytes, then an optional plain byte
    typedef struct packed {
        logic [31:0] num;        // numeric value, emitted little-endian
        logic [2:0]  num_bytes;  // fixed byte count when num_min is low
        logic        num_min;    // emit minimal little-endian bytes of num
        logic        tail_en;    // a plain byte follows the number
        logic [7:0]  tail;       // the plain byte
    } t_job;

endpackage

/* sv/escape_sequence_decoder.sv */
// ----------------------------------------------------------------------------
// escape_sequence_decoder
// backslash escape decoder with a queue interface on both sides
// ----------------------------------------------------------------------------
// One source byte is taken per clock while full is low. The front decodes
// the byte in the same cycle and, if it yields output, writes one job into a
// P_JOB_DEPTH-entry job queue. The back takes one job at a time and, while
// pop keeps up, sends one result byte per cycle through the output register;
// a byte yields k results (k from 1 to 5). The next job is loaded in the
// cycle its predecessor's last byte leaves, keeping the output at one byte
// per cycle while pop keeps up. From an idle block, the first result of a
// byte passes the job queue, the back's job registers and the output register
// before it shows on the result ports. Input stalls only when the results of
// several bytes pile up faster than they are popped and fill the job queue.
// ----------------------------------------------------------------------------
module escape_sequence_decoder #(
    parameter int P_JOB_DEPTH = esd_pkg::JOB_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // source side
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_text,
    // result side
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_out_byte,
    output logic       o_run_last
);
    import esd_pkg::*;

    logic w_accept;     // source byte transfer
    logic w_job_push;   // front has a job for this byte
    t_job w_job;
    t_job w_head;       // oldest job in the queue
    logic w_q_empty;
    logic w_q_pop;

    // a byte is taken whenever the queue has room, even if it yields nothing
    assign w_accept = push && !full;

    esd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .o_job_push    (w_job_push),
        .o_job         (w_job)
    );

    esd_jobq #(
        .P_DEPTH (P_JOB_DEPTH)
    ) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_job   (w_job),
        .i_pop   (w_q_pop),
        .o_head  (w_head),
        .o_empty (w_q_empty),
        .o_full  (full)
    );

    // back side serializes jobs into result transfers
    esd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (w_head),
        .i_q_empty  (w_q_empty),
        .o_q_pop    (w_q_pop),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_out_byte (o_out_byte),
        .o_run_last (o_run_last)
    );

endmodule

/* sv/esd_front.sv */
// ----------------------------------------------------------------------------
// esd_front
// accepts source bytes, tracks the escape state and builds at most one job per byte
// ----------------------------------------------------------------------------
module esd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_in_byte,
    input  logic          i_end_of_text,
    output logic          o_job_push,
    output esd_pkg::t_job o_job
);
    import esd_pkg::*;

    typedef enum logic [3:0] {
        MODE_NORMAL = 4'd0,
        MODE_ESC    = 4'd1,
        MODE_CTRL   = 4'd2,
        MODE_DEC    = 4'd3,
        MODE_HEX1   = 4'd4,
        MODE_GROUP  = 4'd5,
        MODE_FREE   = 4'd6
    } t_mode;

    localparam logic [7:0]  CH_BSLASH = 8'h5c;
    localparam logic [7:0]  CH_ZERO   = 8'h30;
    localparam logic [7:0]  CH_NINE   = 8'h39;
    localparam logic [31:0] DEC_LIM_D = 32'h0000_0100;
    localparam logic [31:0] DEC_LIM_W = 32'hffff_ffff / 32'd10;
    localparam logic [31:0] FREE_LIM  = 32'h1000_0000;
    localparam logic [7:0]  CTRL_MASK = 8'h1f;

    function automatic logic [4:0] hex_nib(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
        else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
        else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
        return r;
    endfunction

    t_mode       r_mode, n_mode;
    logic [7:0]  r_letter, n_letter;
    logic [31:0] r_acc, n_acc;
    logic [3:0]  r_cnt, n_cnt;

    logic [7:0]  w_b;
    logic        w_eot;
    logic [4:0]  w_hex;
    logic        w_hv;
    logic        w_dig;
    logic        w_first;
    logic        w_ok;
    logic        w_plain;
    logic [3:0]  w_cnt_inc;
    logic [31:0] w_acc_dec;
    logic [31:0] w_acc_hex;
    logic [31:0] w_dec_lim;
    t_job        w_job;

    assign w_b       = i_in_byte;
    assign w_eot     = i_end_of_text;
    assign w_hex     = hex_nib(w_b);
    assign w_hv      = w_hex[4];
    assign w_dig     = (w_b >= CH_ZERO) && (w_b <= CH_NINE);
    assign w_first   = (r_cnt == 4'd0);
    assign w_cnt_inc = (r_cnt == 4'hf) ? 4'hf : r_cnt + 4'd1;
    assign w_acc_dec = (r_acc << 3) + (r_acc << 1) + {28'd0, w_hex[3:0]};
    assign w_acc_hex = {r_acc[27:0], w_hex[3:0]};
    assign w_dec_lim = (r_letter == "d") ? DEC_LIM_D : DEC_LIM_W;

    always_comb begin
        case (r_mode)
            MODE_CTRL: w_ok = (w_b >= 8'h40) && (w_b <= 8'h5f);
            MODE_DEC:  w_ok = w_dig;
            default:   w_ok = w_hv;
        endcase
    end

    always_comb begin
        w_job    = '0;
        w_plain  = 1'b0;
        n_mode   = r_mode;
        n_letter = r_letter;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        if ((r_mode == MODE_CTRL || r_mode == MODE_DEC || r_mode == MODE_HEX1 ||
             r_mode == MODE_GROUP || r_mode == MODE_FREE) && w_first && !w_ok) begin
            // argument missing: the letter itself, then the byte as text
            w_job.num       = {24'd0, r_letter};
            w_job.num_bytes = 3'd1;
            w_plain         = 1'b1;
        end else begin
            case (r_mode)
                MODE_ESC: begin
                    n_mode      = MODE_NORMAL;
                    w_job.tail_en = 1'b1;
                    case (w_b)
                        "0":     w_job.tail = 8'h00;
                        "a":     w_job.tail = 8'h07;
                        "b":     w_job.tail = 8'h08;
                        "f":     w_job.tail = 8'h0c;
                        "n":     w_job.tail = 8'h0a;
                        "r":     w_job.tail = 8'h0d;
                        "t":     w_job.tail = 8'h09;
                        "v":     w_job.tail = 8'h0b;
                        "c", "d", "D", "x", "y", "X", "Y": begin
                            w_job.tail = w_b;
                            if (!w_eot) begin
                                w_job.tail_en = 1'b0;
                                n_letter      = w_b;
                                n_acc         = '0;
                                n_cnt         = '0;
                                case (w_b)
                                    "c":      n_mode = MODE_CTRL;
                                    "d", "D": n_mode = MODE_DEC;
                                    "x":      n_mode = MODE_HEX1;
                                    "Y":      n_mode = MODE_FREE;
                                    default:  n_mode = MODE_GROUP;
                                endcase
                            end
                        end
                        default: w_job.tail = w_b;
                    endcase
                end
                MODE_CTRL: begin
                    n_mode        = MODE_NORMAL;
                    w_job.tail_en = 1'b1;
                    w_job.tail    = w_b & CTRL_MASK;
                end
                MODE_DEC: begin
                    w_job.num_min = 1'b1;
                    if (w_dig && r_acc < w_dec_lim) begin
                        n_acc = w_acc_dec;
                        n_cnt = w_cnt_inc;
                        if (w_eot) begin
                            w_job.num = w_acc_dec;
                        end else begin
                            w_job.num_min = 1'b0;
                        end
                    end else begin
                        w_job.num = r_acc;
                        w_plain   = 1'b1;
                    end
                end
                MODE_HEX1: begin
                    w_job.num_bytes = 3'd1;
                    if (w_first) begin
                        n_acc = {28'd0, w_hex[3:0]};
                        n_cnt = 4'd1;
                        w_job.num = {28'd0, w_hex[3:0]};
                        if (!w_eot) w_job.num_bytes = 3'd0;
                    end else if (w_hv) begin
                        w_job.num = w_acc_hex;
                        n_mode    = MODE_NORMAL;
                    end else begin
                        w_job.num = r_acc;
                        w_plain   = 1'b1;
                    end
                end
                MODE_GROUP: begin
                    w_job.num_bytes = (r_letter == "y") ? 3'd2 : 3'd4;
                    if (!w_hv) begin
                        w_job.num = r_acc;
                        w_plain   = 1'b1;
                    end else begin
                        n_acc     = w_acc_hex;
                        n_cnt     = w_cnt_inc;
                        w_job.num = w_acc_hex;
                        if (w_cnt_inc >= ((r_letter == "y") ? 4'd4 : 4'd8) || w_eot) begin
                            n_mode = MODE_NORMAL;
                        end else begin
                            w_job.num_bytes = 3'd0;
                        end
                    end
                end
                MODE_FREE: begin
                    w_job.num_min = 1'b1;
                    if (w_hv && r_acc < FREE_LIM) begin
                        n_acc = w_acc_hex;
                        n_cnt = w_cnt_inc;
                        if (w_eot) begin
                            w_job.num = w_acc_hex;
                        end else begin
                            w_job.num_min = 1'b0;
                        end
                    end else begin
                        w_job.num = r_acc;
                        w_plain   = 1'b1;
                    end
                end
                default: w_plain = 1'b1;
            endcase
        end
        if (w_plain) begin
            n_mode = MODE_NORMAL;
            if (w_b == CH_BSLASH && !w_eot) begin
                n_mode = MODE_ESC;
            end else begin
                w_job.tail_en = 1'b1;
                w_job.tail    = w_b;
            end
        end
        if (w_eot) n_mode = MODE_NORMAL;
    end

    assign o_job      = w_job;
    assign o_job_push = i_accept &&
                        (w_job.num_min || w_job.num_bytes != 3'd0 || w_job.tail_en);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_NORMAL;
            r_letter <= '0;
            r_acc    <= '0;
            r_cnt    <= '0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_letter <= n_letter;
            r_acc    <= n_acc;
            r_cnt    <= n_cnt;
        end
    end

    a_eot_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_end_of_text) |=> (r_mode == MODE_NORMAL))
        else $error("mode not normal after end of text");

    a_push_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_push |-> i_accept)
        else $error("job pushed without an accepted byte");

endmodule

/* sv/esd_jobq.sv */
// ----------------------------------------------------------------------------
// esd_jobq
// small job queue between front and back
// ----------------------------------------------------------------------------
module esd_jobq #(
    parameter int P_DEPTH = esd_pkg::JOB_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  esd_pkg::t_job i_job,
    input  logic          i_pop,
    output esd_pkg::t_job o_head,
    output logic          o_empty,
    output logic          o_full
);
    import esd_pkg::*;

    localparam int AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(P_DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(P_DEPTH);

    t_job          r_mem [P_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_wr, w_rd;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == FULL);
    assign o_head  = r_mem[r_rd];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            if (w_rd) r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            r_cnt <= r_cnt + CW'(w_wr) - CW'(w_rd);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("job pushed into a full queue");

endmodule

/* sv/esd_back.sv */
// ----------------------------------------------------------------------------
// esd_back
// serializes jobs into result bytes through an output register
// ----------------------------------------------------------------------------
module esd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  esd_pkg::t_job i_head,
    input  logic          i_q_empty,
    output logic          o_q_pop,
    output logic          o_empty,
    input  logic          i_pop,
    output logic [7:0]    o_out_byte,
    output logic          o_run_last
);
    import esd_pkg::*;

    logic        r_cur_valid;
    logic [31:0] r_num;
    logic [2:0]  r_left;
    logic        r_tail_en;
    logic [7:0]  r_tail;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;

    logic        w_adv;
    logic        w_emit;
    logic [7:0]  w_byte;
    logic        w_last;
    logic        w_load;
    logic [2:0]  w_min_cnt;

    assign w_adv  = !r_out_valid || i_pop;
    assign w_emit = w_adv && r_cur_valid;
    assign w_byte = (r_left != 3'd0) ? r_num[7:0] : r_tail;
    assign w_last = (r_left == 3'd0) || (r_left == 3'd1 && !r_tail_en);
    assign w_load = !i_q_empty && (!r_cur_valid || (w_emit && w_last));

    always_comb begin
        if (i_head.num[31:24] != 8'd0)      w_min_cnt = 3'd4;
        else if (i_head.num[23:16] != 8'd0) w_min_cnt = 3'd3;
        else if (i_head.num[15:8] != 8'd0)  w_min_cnt = 3'd2;
        else                                w_min_cnt = 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) r_out_valid <= r_cur_valid;
            if (w_load) begin
                r_cur_valid <= 1'b1;
                r_left      <= i_head.num_min ? w_min_cnt : i_head.num_bytes;
            end else if (w_emit) begin
                if (w_last) r_cur_valid <= 1'b0;
                if (r_left != 3'd0) r_left <= r_left - 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_byte <= w_byte;
            r_out_last <= w_last;
        end
        if (w_load) begin
            r_num     <= i_head.num;
            r_tail_en <= i_head.tail_en;
            r_tail    <= i_head.tail;
        end else if (w_emit) begin
            r_num <= r_num >> 8;
        end
    end

    assign o_q_pop    = w_load;
    assign o_empty    = !r_out_valid;
    assign o_out_byte = r_out_byte;
    assign o_run_last = r_out_last;

    a_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_valid |-> (r_left <= 3'd4) && (r_left != 3'd0 || r_tail_en))
        else $error("current job has nothing left to emit");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_last && !w_load) |=> !r_cur_valid)
        else $error("job still active after its last byte");

endmodule

/* tb/sv/escape_sequence_decoder_test.sv */
// ----------------------------------------------------------------------------
// escape_sequence_decoder_test
// self-checking testbench for the backslash escape decoder
// ----------------------------------------------------------------------------
// Source bytes are pushed through the input queue interface and the decoded
// bytes are popped from the result side, both with random idle cycles. A
// behavioral decoder in the testbench predicts the result run of every
// accepted byte, and each popped result is compared with the oldest
// prediction. A short directed part covers the corner cases. A random part
// follows, built mostly from well-formed escapes with random arguments and
// some raw noise bytes.
// ----------------------------------------------------------------------------
module escape_sequence_decoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 12;
    localparam int MAX_WAIT     = 16;    // longest idle draw on either side
    localparam int RANDOM_ITEMS = 145;
    localparam int DRAIN_CYCLES = 16;    // tail after the last prediction
    localparam int STALL_LIMIT  = 2000;  // cycles without any transfer

    // source characters with a meaning to the decoder
    localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [7:0] LTR_CTRL      = "c";
    localparam logic [7:0] LTR_DEC       = "d";
    localparam logic [7:0] LTR_DEC_WIDE  = "D";
    localparam logic [7:0] LTR_HEX       = "x";
    localparam logic [7:0] LTR_HEX16     = "y";
    localparam logic [7:0] LTR_HEX32     = "X";
    localparam logic [7:0] LTR_HEX_FREE  = "Y";

    localparam logic [31:0] DEC_LIMIT      = 32'd256;
    localparam logic [31:0] DEC_WIDE_LIMIT = 32'hFFFF_FFFF / 32'd10;
    localparam logic [31:0] FREE_LIMIT     = 32'h1000_0000;

    // decoder state of the prediction
    typedef enum logic [3:0] {
        ST_TEXT  = 4'd0,
        ST_ESC   = 4'd1,
        ST_CTRL  = 4'd2,
        ST_DEC   = 4'd3,
        ST_HEX1  = 4'd4,
        ST_GROUP = 4'd5,
        ST_FREE  = 4'd6
    } t_decode_state;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_decoded_byte;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] src_byte = 8'h00;
    logic       src_eot = 1'b0;
    logic       empty;
    logic       pop = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_run_last;

    // prediction state
    t_decode_state dec_mode   = ST_TEXT;
    logic [7:0]    esc_letter = 8'h00;
    logic [31:0]   num_acc    = 32'd0;
    logic [3:0]    num_digits = 4'd0;

    t_decoded_byte expected_bytes[$];
    logic [7:0]    run_bytes[$];    // results of the byte being decoded

    int n_errors   = 0;
    int items_sent = 0;
    int idle_count = 0;
    int src_calm   = 0;
    int sink_calm  = 0;

    escape_sequence_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_in_byte     (src_byte),
        .i_end_of_text (src_eot),
        .empty         (empty),
        .pop           (pop),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    function automatic void emit(input logic [31:0] value);
        run_bytes.push_back(value[7:0]);
    endfunction

    // minimal little-endian bytes, one to four
    function automatic void emit_min(input logic [31:0] value);
        emit(value);
        if (value >= 32'h100) emit(value >> 8);
        if (value >= 32'h1_0000) emit(value >> 16);
        if (value >= 32'h100_0000) emit(value >> 24);
    endfunction

    function automatic void emit_fixed(input logic [31:0] value, input int nbytes);
        for (int i = 0; i < nbytes; i++) emit(value >> (8 * i));
    endfunction

    // byte taken as ordinary text, a backslash opens an escape
    function automatic void take_as_text(input logic [7:0] b, input logic eot);
        dec_mode = ST_TEXT;
        if (b == CH_BACKSLASH) begin
            if (eot) emit({24'd0, b});
            else dec_mode = ST_ESC;
        end else begin
            emit({24'd0, b});
        end
    endfunction

    function automatic void count_digit();
        if (num_digits != 4'hF) num_digits = num_digits + 4'd1;
    endfunction

    // advance the predicted decoder by one source byte and queue its results
    function automatic void decode_source_byte(input logic [7:0] b, input logic eot);
        logic [3:0]  nib;
        bit          is_hex;
        bit          is_dig;
        bit          arg_ok;
        bit          done;
        logic [31:0] limit;
        int          nbytes;
        int          need;
        t_decoded_byte item;

        run_bytes.delete();
        done   = 1'b0;
        is_dig = (b >= "0" && b <= "9");
        is_hex = 1'b1;
        if (is_dig) nib = 4'(b - "0");
        else if (b >= "a" && b <= "f") nib = 4'(b - "a" + 8'd10);
        else if (b >= "A" && b <= "F") nib = 4'(b - "A" + 8'd10);
        else begin
            nib    = 4'h0;
            is_hex = 1'b0;
        end

        // missing argument: the escape letter comes out, the byte is text
        if (dec_mode >= ST_CTRL && dec_mode <= ST_FREE) begin
            if (dec_mode == ST_CTRL) arg_ok = (b >= 8'h40 && b <= 8'h5F);
            else if (dec_mode == ST_DEC) arg_ok = is_dig;
            else arg_ok = is_hex;
            if (num_digits == 4'd0 && !arg_ok) begin
                emit({24'd0, esc_letter});
                take_as_text(b, eot);
                done = 1'b1;
            end
        end

        if (!done) begin
            case (dec_mode)
                ST_ESC: begin
                    dec_mode = ST_TEXT;
                    case (b)
                        "0": emit(32'h00);
                        "a": emit(32'h07);
                        "b": emit(32'h08);
                        "f": emit(32'h0C);
                        "n": emit(32'h0A);
                        "r": emit(32'h0D);
                        "t": emit(32'h09);
                        "v": emit(32'h0B);
                        LTR_CTRL, LTR_DEC, LTR_DEC_WIDE, LTR_HEX, LTR_HEX16,
                        LTR_HEX32, LTR_HEX_FREE: begin
                            if (eot) begin
                                emit({24'd0, b});
                            end else begin
                                esc_letter = b;
                                num_acc    = 32'd0;
                                num_digits = 4'd0;
                                case (b)
                                    LTR_CTRL:              dec_mode = ST_CTRL;
                                    LTR_DEC, LTR_DEC_WIDE: dec_mode = ST_DEC;
                                    LTR_HEX:               dec_mode = ST_HEX1;
                                    LTR_HEX_FREE:          dec_mode = ST_FREE;
                                    default:               dec_mode = ST_GROUP;
                                endcase
                            end
                        end
                        default: emit({24'd0, b});
                    endcase
                end
                ST_CTRL: begin
                    dec_mode = ST_TEXT;
                    emit({24'd0, b & 8'h1F});
                end
                ST_DEC: begin
                    limit = (esc_letter == LTR_DEC) ? DEC_LIMIT : DEC_WIDE_LIMIT;
                    if (!is_dig || num_acc >= limit) begin
                        // terminator or digit past the limit
                        emit_min(num_acc);
                        take_as_text(b, eot);
                    end else begin
                        num_acc = num_acc * 32'd10 + {28'd0, nib};
                        count_digit();
                        if (eot) begin
                            emit_min(num_acc);
                            dec_mode = ST_TEXT;
                        end
                    end
                end
                ST_HEX1: begin
                    if (num_digits == 4'd0) begin
                        num_acc    = {28'd0, nib};
                        num_digits = 4'd1;
                        if (eot) begin
                            emit(num_acc);
                            dec_mode = ST_TEXT;
                        end
                    end else if (is_hex) begin
                        emit({num_acc[27:0], nib});
                        dec_mode = ST_TEXT;
                    end else begin
                        emit(num_acc);
                        take_as_text(b, eot);
                    end
                end
                ST_GROUP: begin
                    nbytes = (esc_letter == LTR_HEX16) ? 2 : 4;
                    need   = (esc_letter == LTR_HEX16) ? 4 : 8;
                    if (!is_hex) begin
                        // partial group still gives the full byte count
                        emit_fixed(num_acc, nbytes);
                        take_as_text(b, eot);
                    end else begin
                        num_acc = {num_acc[27:0], nib};
                        count_digit();
                        if (int'(num_digits) >= need || eot) begin
                            emit_fixed(num_acc, nbytes);
                            dec_mode = ST_TEXT;
                        end
                    end
                end
                ST_FREE: begin
                    if (!is_hex || num_acc >= FREE_LIMIT) begin
                        emit_min(num_acc);
                        take_as_text(b, eot);
                    end else begin
                        num_acc = {num_acc[27:0], nib};
                        count_digit();
                        if (eot) begin
                            emit_min(num_acc);
                            dec_mode = ST_TEXT;
                        end
                    end
                end
                default: take_as_text(b, eot);
            endcase
        end

        if (eot) dec_mode = ST_TEXT;
        foreach (run_bytes[i]) begin
            item.data = run_bytes[i];
            item.last = (i == run_bytes.size() - 1);
            expected_bytes.push_back(item);
        end
    endfunction

    // ------------------------------------------------------------------------
    // monitor: both handshakes are seen at the same rising edge, results are
    // checked before the byte accepted at that edge is predicted
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_decoded_byte want;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected result: out_byte %h run_last %b",
                           o_out_byte, o_run_last);
                    n_errors++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_out_byte !== want.data) begin
                        $error("out_byte: expected %h, actual %h", want.data, o_out_byte);
                        n_errors++;
                    end
                    if (o_run_last !== want.last) begin
                        $error("run_last: expected %b, actual %b", want.last, o_run_last);
                        n_errors++;
                    end
                end
            end
            if (push && !full) decode_source_byte(src_byte, src_eot);

            // watchdog on cycles without any transfer
            if ((pop && !empty) || (push && !full)) idle_count = 0;
            else idle_count++;
            if (idle_count >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // idling: a random wait before each transfer, with stretches of none
    // ------------------------------------------------------------------------
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 11) == 0) calm = $urandom_range(8, 30);
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // result side: pop with random stalls
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = draw_wait(sink_calm);
            @(negedge i_clk);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    // one source byte transfer; push stays high when the next byte follows
    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        gap = draw_wait(src_calm);
        @(negedge i_clk);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push     <= 1'b1;
        src_byte <= b;
        src_eot  <= eot;
        do @(posedge i_clk); while (full);
        items_sent++;
    endtask

    task automatic send_text(input string s, input bit eot_at_end);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eot_at_end && (i == s.len() - 1));
    endtask

    function automatic logic [7:0] pick_hex_digit();
        int v;
        v = $urandom_range(0, 21);
        if (v < 10) return 8'("0" + v);
        if (v < 16) return 8'("a" + v - 10);
        return 8'("A" + v - 16);
    endfunction

    // byte extremes, the double backslash and a newline escape
    task automatic test_plain_and_extremes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("\\\\", 1'b0);
        send_text("\\n", 1'b0);
    endtask

    // control escape, here with the highest control byte
    task automatic test_control_escape();
        send_text("\\c_", 1'b0);
    endtask

    // decimal digit past the limit ends the number, the digit follows
    task automatic test_decimal_limit();
        send_text("\\d2567", 1'b0);
    endtask

    // partial group ended by a backslash that opens a full group,
    // then the byte after the full group as text
    task automatic test_hex_groups();
        send_text("\\y12\\yABCD!", 1'b0);
    endtask

    // missing argument, pending number at end of text, lone backslash at end
    // and an escape letter cut off by the end of text
    task automatic test_missing_and_end_cases();
        send_text("\\Yq", 1'b0);
        send_text("\\x7", 1'b1);
        send_text("\\", 1'b1);
        send_text("\\d", 1'b1);
    endtask

    // mostly well-formed escapes with random arguments, plus raw noise
    task automatic test_random_streams(input int n_items);
        logic [7:0] seq[$];
        logic [7:0] ltr;
        string      simple_ltrs;
        string      num_ltrs;
        int         target;
        int         kind;
        int         max_dig;
        int         ndig;
        bit         eot_end;

        simple_ltrs = "\\0abfnrtvqZ";
        num_ltrs    = "dDxyXY";
        target      = items_sent + n_items;
        while (items_sent < target) begin
            seq.delete();
            kind = $urandom_range(0, 11);
            case (kind)
                0, 1: seq.push_back(8'($urandom_range(0, 255)));
                2, 3: begin
                    seq.push_back(CH_BACKSLASH);
                    if ($urandom_range(0, 3) == 0) seq.push_back(8'($urandom_range(0, 255)));
                    else seq.push_back(simple_ltrs[$urandom_range(0, simple_ltrs.len() - 1)]);
                end
                4: begin
                    seq.push_back(CH_BACKSLASH);
                    seq.push_back(LTR_CTRL);
                    if ($urandom_range(0, 4) == 0) seq.push_back(8'($urandom_range(0, 255)));
                    else seq.push_back(8'($urandom_range(8'h40, 8'h5F)));
                end
                default: begin
                    ltr = num_ltrs[$urandom_range(0, num_ltrs.len() - 1)];
                    case (ltr)
                        LTR_DEC:      max_dig = 4;
                        LTR_DEC_WIDE: max_dig = 11;
                        LTR_HEX:      max_dig = 3;
                        LTR_HEX16:    max_dig = 5;
                        default:      max_dig = 9;
                    endcase
                    // no digit at all gives a missing argument
                    ndig = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, max_dig);
                    seq.push_back(CH_BACKSLASH);
                    seq.push_back(ltr);
                    for (int i = 0; i < ndig; i++) begin
                        if (ltr == LTR_DEC || ltr == LTR_DEC_WIDE)
                            seq.push_back(8'("0" + $urandom_range(0, 9)));
                        else
                            seq.push_back(pick_hex_digit());
                    end
                    if ($urandom_range(0, 1) == 1) seq.push_back(8'($urandom_range(0, 255)));
                end
            endcase
            eot_end = ($urandom_range(0, 5) == 0);
            foreach (seq[i]) send_byte(seq[i], eot_end && (i == seq.size() - 1));
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence of the run
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_plain_and_extremes();
        test_control_escape();
        test_decimal_limit();
        test_hex_groups();
        test_missing_and_end_cases();
        test_random_streams(RANDOM_ITEMS);

        @(negedge i_clk);
        push <= 1'b0;

        // drain, then give a stray result time to show up
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* escape_sequence_decoder.f */
sv/esd_pkg.sv
sv/esd_front.sv
sv/esd_jobq.sv
sv/esd_back.sv
sv/escape_sequence_decoder.sv
tb/sv/escape_sequence_decoder_test.sv
